// File: rtl/crfa_pkg.sv
// Package for the compact radial field accumulator.
// Holds widths, the queue depth and the back-end state enum; no dependencies.
package crfa_pkg;

  localparam int CoordWidth     = 24;
  localparam int WeightFracBits = 16;
  localparam int DispWidth      = 32;
  localparam int QueueDepth     = 2;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_DIV,
    BE_SQRT,
    BE_WEIGHT,
    BE_SCALE,
    BE_ACCUM,
    BE_EMIT
  } be_state_e;

endpackage

// File: rtl/crfa_if.sv
// Valid/ready channel interface for the compact radial field accumulator.
// Payload width is a parameter; depends on nothing else.
interface crfa_if #(
  parameter int Width = 8
) (
  input logic clk_i
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/crfa_front.sv
// Front end: accepts an item, forms the per-axis distances and the squared terms,
// classifies it as in or out of support, and pushes a task into a small queue.
// Depends on crfa_pkg.
module crfa_front #(
  parameter int CoordW = crfa_pkg::CoordWidth,
  parameter int QDepth = crfa_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CoordW-1:0]   px_i, py_i, pz_i, nx_i, ny_i, nz_i,
  input  logic [CoordW-2:0]   radius_i,
  input  logic [CoordW-1:0]   wx_i, wy_i, wz_i,
  input  logic                last_i,
  output logic                task_valid_o,
  input  logic                task_ready_i,
  output logic                task_hit_o,
  output logic                task_last_o,
  output logic [2*CoordW+1:0] task_d2_o,
  output logic [2*CoordW-1:0] task_r2_o,
  output logic [CoordW-1:0]   task_wx_o, task_wy_o, task_wz_o
);
  localparam int D2W = 2 * CoordW + 2;
  localparam int R2W = 2 * CoordW;
  localparam int TW  = 2 + D2W + R2W + 3 * CoordW;
  localparam int PW  = (QDepth > 1) ? $clog2(QDepth) : 1;

  // Stage 1: absolute differences.
  logic              s1_q;
  logic [CoordW:0]   dx_q, dy_q, dz_q;
  logic [CoordW-2:0] r_q;
  logic [CoordW-1:0] wx_q, wy_q, wz_q;
  logic              l_q;
  logic              adv1;
  logic [CoordW:0]   dx_d, dy_d, dz_d;

  // Stage 2: squares and hit classification.
  logic              s2_q;
  logic [R2W+1:0]    sx_q, sy_q, sz_q;
  logic [R2W-1:0]    r2_q;
  logic              near_q;
  logic [CoordW-1:0] wx2_q, wy2_q, wz2_q;
  logic              l2_q;
  logic              adv2;

  logic [TW-1:0] mem_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;
  logic [D2W-1:0] d2;
  logic [TW-1:0]  head;

  function automatic logic [CoordW:0] absdiff(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic signed [CoordW:0] d;
    d = $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
    return d[CoordW] ? -d : d;
  endfunction

  assign dx_d = absdiff(px_i, nx_i);
  assign dy_d = absdiff(py_i, ny_i);
  assign dz_d = absdiff(pz_i, nz_i);

  // Stage 2 can only advance if the queue has a free entry.
  assign adv2 = s2_q && (cnt_q < (PW+1)'(QDepth));
  assign adv1 = !s2_q || adv2;
  assign in_ready_o = !s1_q || adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_q <= in_valid_i;
      if (adv1) s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      dz_q <= dz_d;
      r_q  <= radius_i;
      wx_q <= wx_i;
      wy_q <= wy_i;
      wz_q <= wz_i;
      l_q  <= last_i;
    end
    if (adv1 && s1_q) begin
      sx_q   <= (R2W+2)'(dx_q * dx_q);
      sy_q   <= (R2W+2)'(dy_q * dy_q);
      sz_q   <= (R2W+2)'(dz_q * dz_q);
      r2_q   <= R2W'(r_q * r_q);
      near_q <= (dx_q < {2'b00, r_q}) && (dy_q < {2'b00, r_q}) && (dz_q < {2'b00, r_q});
      wx2_q  <= wx_q;
      wy2_q  <= wy_q;
      wz2_q  <= wz_q;
      l2_q   <= l_q;
    end
  end

  assign d2   = sx_q + sy_q + sz_q;
  assign push = adv2;
  assign pop  = task_valid_o && task_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= (rp_q == PW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= {near_q && (d2 < {2'b00, r2_q}), l2_q, d2, r2_q, wx2_q, wy2_q, wz2_q};
    end
  end

  assign task_valid_o = (cnt_q != '0);
  assign head = mem_q[rp_q];
  assign {task_hit_o, task_last_o, task_d2_o, task_r2_o, task_wx_o, task_wy_o, task_wz_o} = head;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QDepth)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PW+1)'(QDepth)) |-> !push) else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count step");
`endif
endmodule

// File: rtl/crfa_back.sv
// Back end: for an in-support task divides d2 by r2, takes the square root, forms
// the weight and scales the push vector; every task updates the saturating sums,
// a miss adding zero, and emits on the last item. Depends on crfa_pkg.
module crfa_back #(
  parameter int CoordW = crfa_pkg::CoordWidth,
  parameter int FracW  = crfa_pkg::WeightFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                task_valid_i,
  output logic                task_ready_o,
  input  logic                task_hit_i,
  input  logic                task_last_i,
  input  logic [2*CoordW+1:0] task_d2_i,
  input  logic [2*CoordW-1:0] task_r2_i,
  input  logic [CoordW-1:0]   task_wx_i, task_wy_i, task_wz_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [crfa_pkg::DispWidth-1:0] disp_x_o, disp_y_o, disp_z_o
);
  localparam int DW  = crfa_pkg::DispWidth;
  localparam int R2W = 2 * CoordW;
  localparam int RMW = R2W + 2;
  localparam int SQW = 2 * FracW;
  localparam int CTW = $clog2(SQW + 1);
  localparam int MW  = CoordW + FracW + 1;
  localparam logic signed [DW+1:0] SatMax = (DW+2)'((64'sd1 <<< (DW-1)) - 1);
  localparam logic signed [DW+1:0] SatMin = -(DW+2)'(64'sd1 <<< (DW-1));

  crfa_pkg::be_state_e st_q, st_d;
  logic [CTW-1:0]    ct_q, ct_d;
  logic [RMW-1:0]    rem_q, rem_d;
  logic [R2W-1:0]    r2_q;
  logic [SQW-1:0]    q_q, q_d;
  logic [SQW+1:0]    srem_q, srem_d;
  logic [FracW:0]    s_q, s_d;
  logic [FracW:0]    w_q, w_d;
  logic [1:0]        ax_q, ax_d;
  logic [CoordW-1:0] wx_q, wy_q, wz_q;
  logic              last_q;
  logic signed [DW-1:0] acc_q [3];
  logic signed [CoordW:0] term_q [3];
  logic signed [CoordW:0] term_d;
  logic [CoordW-1:0] push_sel;
  logic [CoordW-1:0] pmag;
  logic [MW-1:0]     mag;
  logic [RMW-1:0]    rsh;
  logic [SQW+1:0]    sh, trial;
  logic [FracW+1:0]  om;
  logic [2*FracW+3:0] omsq;
  logic signed [DW+1:0] sum [3];
  logic [DW-1:0] ox_q, oy_q, oz_q;
  logic          ov_q;
  logic          take;

  assign take = task_valid_i && task_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= crfa_pkg::BE_IDLE;
    else st_q <= st_d;
  end

  always_comb begin
    push_sel = wx_q;
    case (ax_q)
      2'd1: push_sel = wy_q;
      2'd2: push_sel = wz_q;
      default: push_sel = wx_q;
    endcase
    pmag  = push_sel[CoordW-1] ? -push_sel : push_sel;
    mag   = MW'(pmag * w_q);
    if (push_sel[CoordW-1]) begin
      term_d = -$signed((CoordW+1)'((mag + MW'((1 << FracW) - 1)) >> FracW));
    end else begin
      term_d = $signed((CoordW+1)'(mag >> FracW));
    end
    rsh   = rem_q << 1;
    sh    = {srem_q[SQW-1:0], q_q[SQW-1 -: 2]};
    trial = {s_q, 2'b01};
    om    = (FracW+2)'(1 << FracW) - {1'b0, s_q};
    omsq  = om * om;
    for (int i = 0; i < 3; i++) sum[i] = (DW+2)'(acc_q[i]) + (DW+2)'(term_q[i]);
  end

  always_comb begin
    st_d = st_q;
    ct_d = ct_q;
    rem_d = rem_q;
    q_d = q_q;
    srem_d = srem_q;
    s_d = s_q;
    w_d = w_q;
    ax_d = ax_q;
    task_ready_o = 1'b0;
    case (st_q)
      crfa_pkg::BE_IDLE: begin
        task_ready_o = 1'b1;
        if (task_valid_i) begin
          rem_d = {2'b00, task_d2_i[R2W-1:0]};
          q_d = '0;
          ct_d = '0;
          st_d = task_hit_i ? crfa_pkg::BE_DIV : crfa_pkg::BE_ACCUM;
        end
      end
      crfa_pkg::BE_DIV: begin
        if (rsh >= {2'b00, r2_q}) begin
          rem_d = rsh - {2'b00, r2_q};
          q_d = {q_q[SQW-2:0], 1'b1};
        end else begin
          rem_d = rsh;
          q_d = {q_q[SQW-2:0], 1'b0};
        end
        ct_d = ct_q + 1'b1;
        if (ct_q == CTW'(FracW - 1)) begin
          q_d = {q_d[FracW-1:0], {FracW{1'b0}}};
          srem_d = '0;
          s_d = '0;
          ct_d = '0;
          st_d = crfa_pkg::BE_SQRT;
        end
      end
      crfa_pkg::BE_SQRT: begin
        if (sh >= trial) begin
          srem_d = sh - trial;
          s_d = {s_q[FracW-1:0], 1'b1};
        end else begin
          srem_d = sh;
          s_d = {s_q[FracW-1:0], 1'b0};
        end
        q_d = q_q << 2;
        ct_d = ct_q + 1'b1;
        if (ct_q == CTW'(FracW - 1)) st_d = crfa_pkg::BE_WEIGHT;
      end
      crfa_pkg::BE_WEIGHT: begin
        w_d = (FracW+1)'(omsq >> FracW);
        ax_d = 2'd0;
        st_d = crfa_pkg::BE_SCALE;
      end
      crfa_pkg::BE_SCALE: begin
        ax_d = ax_q + 1'b1;
        if (ax_q == 2'd2) st_d = crfa_pkg::BE_ACCUM;
      end
      crfa_pkg::BE_ACCUM: begin
        st_d = last_q ? crfa_pkg::BE_EMIT : crfa_pkg::BE_IDLE;
      end
      crfa_pkg::BE_EMIT: begin
        if (!ov_q || out_ready_i) st_d = crfa_pkg::BE_IDLE;
      end
      default: st_d = crfa_pkg::BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ct_q <= ct_d;
    rem_q <= rem_d;
    q_q <= q_d;
    srem_q <= srem_d;
    s_q <= s_d;
    w_q <= w_d;
    ax_q <= ax_d;
    if (take) begin
      r2_q <= task_r2_i;
      wx_q <= task_wx_i;
      wy_q <= task_wy_i;
      wz_q <= task_wz_i;
      last_q <= task_last_i;
      for (int i = 0; i < 3; i++) term_q[i] <= '0;
    end
    if (st_q == crfa_pkg::BE_SCALE) term_q[ax_q] <= term_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) acc_q[i] <= '0;
      ov_q <= 1'b0;
    end else begin
      if (st_q == crfa_pkg::BE_EMIT && (!ov_q || out_ready_i)) ov_q <= 1'b1;
      else if (out_valid_o && out_ready_i) ov_q <= 1'b0;
      if (st_q == crfa_pkg::BE_ACCUM) begin
        for (int i = 0; i < 3; i++) begin
          if (sum[i] > SatMax) acc_q[i] <= DW'(SatMax);
          else if (sum[i] < SatMin) acc_q[i] <= DW'(SatMin);
          else acc_q[i] <= DW'(sum[i]);
        end
      end
      if (st_q == crfa_pkg::BE_EMIT && (!ov_q || out_ready_i)) begin
        for (int i = 0; i < 3; i++) acc_q[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == crfa_pkg::BE_EMIT && (!ov_q || out_ready_i)) begin
      ox_q <= acc_q[0];
      oy_q <= acc_q[1];
      oz_q <= acc_q[2];
    end
  end

  assign out_valid_o = ov_q;
  assign disp_x_o = ox_q;
  assign disp_y_o = oy_q;
  assign disp_z_o = oz_q;

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (st_q == crfa_pkg::BE_IDLE)) else $error("task taken while busy");
  a_miss_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !task_hit_i) |=> (st_q == crfa_pkg::BE_ACCUM)) else $error("miss path");
  a_weight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == crfa_pkg::BE_SCALE) |-> (w_q <= (FracW+1)'(1 << FracW)))
    else $error("weight above one");
`endif
endmodule

// File: rtl/compact_radial_field_accumulator_unit.sv
// Top level of the compact radial field accumulator.
// Depends on crfa_pkg, crfa_if, crfa_front and crfa_back.
//
// Usage: one input channel carries a voxel position, one control node (source point,
// radius, push vector) and a last flag. Each transaction in support adds
// (1 - sqrt(d2/r2))^2 times the push vector to three saturating Q23.8 sums.
// The transaction flagged last produces one output transaction with the sums
// and clears them. The input payload packs {point_x,point_y,point_z,node_x,
// node_y,node_z,radius,push_x,push_y,push_z,last}, MSB first; the output packs
// {disp_x,disp_y,disp_z}.
// Back-end steps: an in-support transaction passes the hand-off, 16 divider steps,
// 16 square root steps, the weight, a scaling step for each of the three axes and
// the sum update; an out-of-support one goes from the hand-off straight to the sum
// update; a last-flagged one then loads the output register in the emit state.
// The back end takes a new transaction only from its idle state. The front end
// adds the difference and square stages and a two-entry queue, so it keeps
// accepting while the back end works until those fill. Reset clears the sums,
// empties the queue and drops output valid; the output data register is not reset.
// When the receiver stalls, the result waits in the output register and the back
// end holds at the next last-flagged transaction; the queue then fills and input
// ready drops.
module compact_radial_field_accumulator_unit #(
  parameter int COORD_WIDTH      = crfa_pkg::CoordWidth,
  parameter int WEIGHT_FRAC_BITS = crfa_pkg::WeightFracBits
) (
  input logic clk_i,
  input logic rst_ni,
  crfa_if.sink   in_if,
  crfa_if.source out_if
);
  localparam int CW = COORD_WIDTH;
  localparam int DW = crfa_pkg::DispWidth;

  logic            tv, tr, th, tl;
  logic [2*CW+1:0] td2;
  logic [2*CW-1:0] tr2;
  logic [CW-1:0]   twx, twy, twz;

  crfa_front #(.CoordW(CW), .QDepth(crfa_pkg::QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .px_i(in_if.data[10*CW-1 -: CW]), .py_i(in_if.data[9*CW-1 -: CW]),
    .pz_i(in_if.data[8*CW-1 -: CW]), .nx_i(in_if.data[7*CW-1 -: CW]),
    .ny_i(in_if.data[6*CW-1 -: CW]), .nz_i(in_if.data[5*CW-1 -: CW]),
    .radius_i(in_if.data[4*CW-1 -: CW-1]),
    .wx_i(in_if.data[3*CW -: CW]), .wy_i(in_if.data[2*CW -: CW]),
    .wz_i(in_if.data[CW -: CW]), .last_i(in_if.data[0]),
    .task_valid_o(tv), .task_ready_i(tr), .task_hit_o(th), .task_last_o(tl),
    .task_d2_o(td2), .task_r2_o(tr2), .task_wx_o(twx), .task_wy_o(twy), .task_wz_o(twz)
  );

  crfa_back #(.CoordW(CW), .FracW(WEIGHT_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .task_valid_i(tv), .task_ready_o(tr), .task_hit_i(th), .task_last_i(tl),
    .task_d2_i(td2), .task_r2_i(tr2), .task_wx_i(twx), .task_wy_i(twy), .task_wz_i(twz),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .disp_x_o(out_if.data[3*DW-1 -: DW]), .disp_y_o(out_if.data[2*DW-1 -: DW]),
    .disp_z_o(out_if.data[DW-1:0])
  );
endmodule
